// ===== rtl/isr_pkg.sv =====
// shared constants, types and state encoding for the integer square root block
package isr_pkg;

   // width of the radicand that the root is taken over
   localparam int RADICAND_BITS = 32;
   // width of the input and output words
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;
   // highest even bit position below the radicand width
   localparam int TOP_BIT       = ((RADICAND_BITS - 1) / 2) * 2;
   // one digit step per bit pair
   localparam int STEPS         = TOP_BIT / 2 + 1;
   localparam int CNT_BITS      = $clog2(STEPS + 1);
   // largest root the output field can carry
   localparam logic [RSP_DATA_BITS-1:0] ROOT_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } isr_state_type;

   typedef struct packed {
      logic load;     // take a new radicand into the datapath
      logic step;     // perform one digit step
      logic publish;  // copy the finished root into the output register
   } isr_cmd_type;

endpackage

// ===== rtl/integer_square_root.sv =====
// top level of the digit-by-digit integer square root
//
//   channel  | direction | word
//   ---------+-----------+--------------------------------------
//   req_     | in        | tdata[31:0] radicand, unsigned
//   rsp_     | out       | tdata[15:0] root, floor square root
//
// each word is loaded, then takes sixteen digit steps (one bit pair of
// the radicand a cycle through a single compare-and-subtract unit), and
// its root is then moved into the output register
// a new word is taken while the previous root still waits in the output
// register; if that register is still full when the steps end, the
// sequencer holds until it drains
// reset is synchronous and clears only the sequencer and the output valid
module integer_square_root (
   input  logic                               clock,
   input  logic                               reset,
   // radicand in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [isr_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // [31:0] radicand
   // root out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [isr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata    // [15:0] root
);

   // commands from the sequencer to the datapath
   isr_pkg::isr_cmd_type cmd;

   // sequencer: owns the step count and the output valid flag
   isr_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: remainder, partial root, trial bit and output register
   isr_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .radicand (req_tdata),
      .root     (rsp_tdata)
   );

endmodule

// ===== rtl/isr_datapath.sv =====
// remainder, root and trial bit registers with one digit step per cycle
module isr_datapath (
   input  logic                                clock,
   input  isr_pkg::isr_cmd_type                cmd,
   input  logic [isr_pkg::REQ_DATA_BITS-1:0]   radicand,
   output logic [isr_pkg::RSP_DATA_BITS-1:0]   root
);

   localparam int W = isr_pkg::RADICAND_BITS;

   logic [W-1:0] rem_ff,  rem_in;
   logic [W-1:0] acc_ff,  acc_in;
   logic [W-1:0] bit_ff,  bit_in;
   logic [isr_pkg::RSP_DATA_BITS-1:0] root_ff, root_in;
   logic [W:0]   trial;
   logic         take;

   // trial carries one spare bit so the sum never wraps
   assign trial = {1'b0, acc_ff} + {1'b0, bit_ff};
   assign take  = {1'b0, rem_ff} >= trial;

   always_comb begin
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      bit_in  = bit_ff;
      root_in = root_ff;
      if (cmd.load) begin
         rem_in = W'(radicand);
         acc_in = '0;
         bit_in = W'(1) << isr_pkg::TOP_BIT;
      end else if (cmd.step) begin
         if (take) begin
            rem_in = rem_ff - trial[W-1:0];
            acc_in = (acc_ff >> 1) + bit_ff;
         end else begin
            acc_in = acc_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.publish) begin
         // saturate when the radicand is wider than twice the output
         if ((W + 1) / 2 > isr_pkg::RSP_DATA_BITS &&
             acc_ff > W'(isr_pkg::ROOT_MAX)) begin
            root_in = isr_pkg::ROOT_MAX;
         end else begin
            root_in = isr_pkg::RSP_DATA_BITS'(acc_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      bit_ff  <= bit_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// ===== rtl/isr_control.sv =====
// sequencer for load, digit steps and hand-over to the output register
module isr_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output isr_pkg::isr_cmd_type cmd
);

   isr_pkg::isr_state_type       state_ff, state_in;
   logic [isr_pkg::CNT_BITS-1:0] cnt_ff,   cnt_in;
   logic                         valid_ff, valid_in;
   logic                         last_step;
   logic                         slot_free;

   assign last_step = cnt_ff == isr_pkg::CNT_BITS'(isr_pkg::STEPS - 1);
   assign slot_free = !valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = isr_pkg::ST_RUN;
         end
         isr_pkg::ST_RUN: begin
            if (last_step) state_in = isr_pkg::ST_DONE;
         end
         isr_pkg::ST_DONE: begin
            if (slot_free) state_in = isr_pkg::ST_IDLE;
         end
         default: state_in = isr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         isr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         isr_pkg::ST_RUN: begin
            cmd.step = 1'b1;
         end
         isr_pkg::ST_DONE: begin
            cmd.publish = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      valid_in = valid_ff;
      if (cmd.publish) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isr_pkg::ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== verif/tb_integer_square_root.sv =====
// testbench for the integer square root block: random and corner radicands checked word by word
`timescale 1ns / 1ps

module tb_integer_square_root;

   localparam int RANDOM_PER_PHASE = 550;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 400000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [isr_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;   // [31:0] radicand
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [isr_pkg::RSP_DATA_BITS-1:0] rsp_tdata;        // [15:0] root

   // radicands waiting to be offered, roots waiting to come back
   logic [isr_pkg::REQ_DATA_BITS-1:0] pending_radicands[$];
   logic [isr_pkg::RSP_DATA_BITS-1:0] expected_roots[$];

   int unsigned sender_idle_pct   = 29;
   int unsigned receiver_idle_pct = 46;
   int unsigned failures          = 0;
   int unsigned cycle_count       = 0;

   integer_square_root i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // restoring digit-by-digit root over the full radicand width, no shortcuts
   function automatic logic [isr_pkg::RSP_DATA_BITS-1:0] floor_sqrt(
      input logic [isr_pkg::REQ_DATA_BITS-1:0] value
   );
      logic [isr_pkg::REQ_DATA_BITS-1:0] remainder;
      logic [isr_pkg::REQ_DATA_BITS-1:0] partial;
      logic [isr_pkg::REQ_DATA_BITS-1:0] digit;
      remainder = value;
      partial   = '0;
      digit     = 32'h4000_0000;
      while (digit != 0) begin
         if (remainder >= partial + digit) begin
            remainder = remainder - (partial + digit);
            partial   = (partial >> 1) + digit;
         end else begin
            partial = partial >> 1;
         end
         digit = digit >> 2;
      end
      return partial[isr_pkg::RSP_DATA_BITS-1:0];
   endfunction

   // mix of full-width values, short values and neighbours of perfect squares
   function automatic logic [isr_pkg::REQ_DATA_BITS-1:0] random_radicand();
      logic [isr_pkg::RSP_DATA_BITS-1:0] base;
      logic [isr_pkg::REQ_DATA_BITS-1:0] square;
      base   = isr_pkg::RSP_DATA_BITS'($urandom);
      square = base * base;
      case ($urandom_range(3))
         0: begin
            return $urandom;
         end
         1: begin
            return $urandom >> $urandom_range(31);
         end
         2: begin
            return square + $urandom_range(2) - 1;
         end
         default: begin
            return square + base + base - $urandom_range(1);
         end
      endcase
   endfunction

   // sender: offers the next radicand once the current word is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_radicands.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_radicands.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure on the root channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // check the oldest expectation first, then predict for the word just taken
   always @(posedge clock) begin : root_monitor
      logic [isr_pkg::RSP_DATA_BITS-1:0] wanted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               $error("root: no word expected, actual %0d", rsp_tdata);
               failures++;
            end else begin
               wanted = expected_roots.pop_front();
               if (rsp_tdata !== wanted) begin
                  $error("root: expected %0d, actual %0d", wanted, rsp_tdata);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_roots.push_back(floor_sqrt(req_tdata));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d roots outstanding", expected_roots.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic wait_all_sent();
      while (pending_radicands.size() != 0 || req_tvalid) @(negedge clock);
   endtask

   task automatic wait_all_returned();
      while (expected_roots.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // corners: zero, tiny values, exact squares and their neighbours, all-ones
      @(negedge clock);
      pending_radicands.push_back(32'h0000_0000);
      pending_radicands.push_back(32'h0000_0001);
      pending_radicands.push_back(32'h0000_0002);
      pending_radicands.push_back(32'h0000_0003);
      pending_radicands.push_back(32'h0000_0004);
      pending_radicands.push_back(32'h0000_000F);
      pending_radicands.push_back(32'h0000_0010);
      pending_radicands.push_back(32'h0000_0011);
      pending_radicands.push_back(32'h0000_0063);
      pending_radicands.push_back(32'h0000_0064);
      pending_radicands.push_back(32'h0000_FFFF);
      pending_radicands.push_back(32'h0001_0000);
      pending_radicands.push_back(32'h3FFF_FFFF);
      pending_radicands.push_back(32'h4000_0000);
      pending_radicands.push_back(32'h5555_5555);
      pending_radicands.push_back(32'h8000_0000);
      pending_radicands.push_back(32'hAAAA_AAAA);
      pending_radicands.push_back(32'hFFFE_0000);
      pending_radicands.push_back(32'hFFFE_0001);
      pending_radicands.push_back(32'hFFFE_0002);
      pending_radicands.push_back(32'hFFFF_FFFE);
      pending_radicands.push_back(32'hFFFF_FFFF);

      // hold off until the block has fully drained
      wait_all_sent();
      wait_all_returned();

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            sender_idle_pct   <= 46;
            receiver_idle_pct <= 29;
         end else if (phase == 2) begin
            sender_idle_pct   <= 0;
            receiver_idle_pct <= 0;
         end
         @(negedge clock);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pending_radicands.push_back(random_radicand());
         end
         wait_all_sent();
      end

      wait_all_returned();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/isr_pkg.sv
rtl/isr_datapath.sv
rtl/isr_control.sv
rtl/integer_square_root.sv
verif/tb_integer_square_root.sv
